// ----- src/dsa_pkg.sv -----
package dsa_pkg;

    // Default heap capacity, in slots
    localparam int CAPACITY_DEF = 1024;

    // Bitmap rows of the L0 and L1 memories of the search tree are 32 bits wide
    localparam int WORD_W  = 32;
    localparam int WORD_LG = 5;

    // Request opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TOTAL_COUNT = 2'd0;
    localparam t_cfg_idx CFG_DESC_SIZE   = 2'd1;
    localparam t_cfg_idx CFG_CPU_BASE    = 2'd2;
    localparam t_cfg_idx CFG_GPU_BASE    = 2'd3;

    localparam logic [10:0] TOTAL_COUNT_RST = 11'd1024;
    localparam logic [12:0] DESC_SIZE_RST   = 13'd32;

    typedef enum logic [1:0] {
        ST_ALLOC     = 2'd0,
        ST_RELEASED  = 2'd1,
        ST_DUP       = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALC_TOP,
        S_ALC_MID,
        S_ALC_LOW,
        S_REL_RD,
        S_REL_WR,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic alc_top;
        logic alc_mid;
        logic alc_low;
        logic rel_rd;
        logic rel_wr;
        logic mul;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic have_recycled;
        logic fresh_avail;
        logic out_free;
    } t_sts;

    // Index of the lowest set bit; zero for an all-zero word
    function automatic logic [4:0] f_lsb32(input logic [31:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (w[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [5:0] f_lsb64(input logic [63:0] w);
        logic [5:0] idx;
        idx = '0;
        for (int i = 63; i >= 0; i--) begin
            if (w[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- src/dsa_ctrl.sv -----
module dsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_op,
    input  dsa_pkg::t_sts   i_sts,
    output logic            o_in_ready,
    output dsa_pkg::t_cmd   o_cmd
);

    dsa_pkg::t_state r_state;
    dsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_op == dsa_pkg::OP_RELEASE) ? dsa_pkg::S_REL_RD
                                                             : dsa_pkg::S_ALC_TOP;
                end
            end
            dsa_pkg::S_ALC_TOP: begin
                o_cmd.alc_top = 1'b1;
                priority if (i_sts.have_recycled) begin
                    n_state = dsa_pkg::S_ALC_MID;
                end else if (i_sts.fresh_avail) begin
                    n_state = dsa_pkg::S_MUL;
                end else begin
                    n_state = dsa_pkg::S_DONE;
                end
            end
            dsa_pkg::S_ALC_MID: begin
                o_cmd.alc_mid = 1'b1;
                n_state = dsa_pkg::S_ALC_LOW;
            end
            dsa_pkg::S_ALC_LOW: begin
                o_cmd.alc_low = 1'b1;
                n_state = dsa_pkg::S_MUL;
            end
            dsa_pkg::S_REL_RD: begin
                o_cmd.rel_rd = 1'b1;
                n_state = dsa_pkg::S_REL_WR;
            end
            dsa_pkg::S_REL_WR: begin
                o_cmd.rel_wr = 1'b1;
                n_state = dsa_pkg::S_DONE;
            end
            dsa_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = dsa_pkg::S_DONE;
            end
            dsa_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = dsa_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule

// ----- src/dsa_dpath.sv -----
module dsa_dpath #(
    parameter int CAPACITY = dsa_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dsa_pkg::t_cmd       i_cmd,
    output dsa_pkg::t_sts       o_sts,
    input  logic                i_cfg_wr_en,
    input  dsa_pkg::t_cfg_idx   i_cfg_addr,
    input  logic [63:0]         i_cfg_data,
    input  logic [9:0]          i_slot_in,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [9:0]          o_slot_out,
    output logic [63:0]         o_cpu_address,
    output logic [63:0]         o_gpu_address,
    output logic [11:0]         o_spare_count
);

    localparam int WW  = dsa_pkg::WORD_W;
    localparam int WL  = dsa_pkg::WORD_LG;
    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = (CW > 11) ? CW : 11;
    localparam int SPW = XW + 1;
    localparam int MW  = (CW > 10) ? CW : 10;
    localparam int D0  = (CAPACITY + WW - 1) / WW;
    localparam int D1  = (D0 + WW - 1) / WW;
    localparam int A0  = (D0 > 1) ? $clog2(D0) : 1;
    localparam int A1  = (D1 > 1) ? $clog2(D1) : 1;
    localparam int PW  = SW + 13;

    // configuration
    logic [10:0]        r_total;
    logic [12:0]        r_dsize;
    logic [63:0]        r_cpu_base;
    logic [63:0]        r_gpu_base;

    // allocator state
    logic [D1-1:0]      r_l2;       // L1 row i is valid and nonzero
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_nf;

    // working registers
    logic [SW-1:0]      r_slot;
    logic               r_inrange;
    logic [A1-1:0]      r_i1;
    logic [A0-1:0]      r_row;
    logic [WL-1:0]      r_j;
    logic [PW-1:0]      r_prod;
    dsa_pkg::t_status   r_status;

    // memories: L0 holds the slot bitmap, L1 the row-nonzero bitmap
    logic [WW-1:0]      m_l0 [D0];
    logic [WW-1:0]      m_l1 [D1];
    logic [WW-1:0]      r_l0_rd;
    logic [WW-1:0]      r_l1_rd;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic [9:0]         r_o_slot;
    logic [63:0]        r_o_cpu;
    logic [63:0]        r_o_gpu;
    logic [11:0]        r_o_spare;

    logic [XW-1:0]      bound;
    logic [XW-1:0]      fresh;
    logic               fresh_avail;
    logic               out_free;
    logic [A1-1:0]      enc_l2;
    logic [WL-1:0]      enc_l1;
    logic [WL-1:0]      enc_l0;
    logic [WW-1:0]      l1_eff;
    logic [WW-1:0]      l0_eff;
    logic [WL-1:0]      k;
    logic [WW-1:0]      k_bit;
    logic [WW-1:0]      j_bit;
    logic [WW-1:0]      l0_clr;
    logic [WW-1:0]      l1_clr;
    logic               dup;
    logic [A0-1:0]      mid_row;
    logic [A0-1:0]      rel_row;
    logic [A1-1:0]      rel_i1;
    logic               l0_re;
    logic               l0_we;
    logic [A0-1:0]      l0_raddr;
    logic [WW-1:0]      l0_wdata;
    logic               l1_re;
    logic               l1_we;
    logic [A1-1:0]      l1_raddr;
    logic [WW-1:0]      l1_wdata;
    logic               is_alloc;

    always_comb begin
        bound = (XW'(r_total) > XW'(CAPACITY)) ? XW'(CAPACITY) : XW'(r_total);
        fresh_avail = XW'(r_nf) < bound;
        fresh = fresh_avail ? (bound - XW'(r_nf)) : '0;
        out_free = !r_out_valid || i_out_ready;

        // an L1 row is only trusted when its L2 bit is set, an L0 row only when its
        // L1 bit is set, so neither memory needs clearing after reset
        l1_eff = r_l2[r_i1] ? r_l1_rd : '0;
        l0_eff = l1_eff[r_j] ? r_l0_rd : '0;

        enc_l2 = A1'(dsa_pkg::f_lsb64(64'(r_l2)));
        enc_l1 = dsa_pkg::f_lsb32(l1_eff);
        enc_l0 = dsa_pkg::f_lsb32(l0_eff);
        mid_row = A0'({r_i1, enc_l1});
        rel_row = A0'(r_slot >> WL);
        rel_i1  = A1'(r_slot >> (2 * WL));

        k      = i_cmd.alc_low ? enc_l0 : WL'(r_slot);
        k_bit  = WW'(1) << k;
        j_bit  = WW'(1) << r_j;
        l0_clr = l0_eff & ~k_bit;
        l1_clr = l1_eff & ~j_bit;
        dup    = !r_inrange || l0_eff[k];

        l0_re    = i_cmd.alc_mid || i_cmd.rel_rd;
        l0_raddr = i_cmd.alc_mid ? mid_row : rel_row;
        l0_we    = i_cmd.alc_low || (i_cmd.rel_wr && !dup);
        l0_wdata = i_cmd.alc_low ? l0_clr : (l0_eff | k_bit);

        l1_re    = i_cmd.alc_top || i_cmd.rel_rd;
        l1_raddr = i_cmd.alc_top ? enc_l2 : rel_i1;
        l1_we    = (i_cmd.alc_low && (l0_clr == '0)) || (i_cmd.rel_wr && !dup);
        l1_wdata = i_cmd.alc_low ? l1_clr : (l1_eff | j_bit);

        is_alloc = (r_status == dsa_pkg::ST_ALLOC);

        o_sts.have_recycled = (r_count != '0);
        o_sts.fresh_avail   = fresh_avail;
        o_sts.out_free      = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (l0_we) begin
            m_l0[r_row] <= l0_wdata;
        end
        if (l0_re) begin
            r_l0_rd <= m_l0[l0_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (l1_we) begin
            m_l1[r_i1] <= l1_wdata;
        end
        if (l1_re) begin
            r_l1_rd <= m_l1[l1_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= dsa_pkg::TOTAL_COUNT_RST;
            r_dsize     <= dsa_pkg::DESC_SIZE_RST;
            r_cpu_base  <= '0;
            r_gpu_base  <= '0;
            r_l2        <= '0;
            r_count     <= '0;
            r_nf        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    dsa_pkg::CFG_TOTAL_COUNT: r_total    <= i_cfg_data[10:0];
                    dsa_pkg::CFG_DESC_SIZE:   r_dsize    <= i_cfg_data[12:0];
                    dsa_pkg::CFG_CPU_BASE:    r_cpu_base <= i_cfg_data;
                    dsa_pkg::CFG_GPU_BASE:    r_gpu_base <= i_cfg_data;
                endcase
            end
            if (i_cmd.alc_top && (r_count == '0) && fresh_avail) begin
                r_nf <= CW'(r_nf + 1'b1);
            end
            if (i_cmd.alc_low) begin
                r_count <= CW'(r_count - 1'b1);
                if ((l0_clr == '0) && (l1_clr == '0)) begin
                    r_l2[r_i1] <= 1'b0;
                end
            end
            if (i_cmd.rel_wr && !dup) begin
                r_count    <= CW'(r_count + 1'b1);
                r_l2[r_i1] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot    <= SW'(i_slot_in);
            r_inrange <= MW'(i_slot_in) < MW'(CAPACITY);
        end
        if (i_cmd.alc_top) begin
            r_i1 <= enc_l2;
            if (r_count == '0) begin
                r_slot   <= SW'(r_nf);
                r_status <= fresh_avail ? dsa_pkg::ST_ALLOC : dsa_pkg::ST_EXHAUSTED;
            end
        end
        if (i_cmd.alc_mid) begin
            r_row <= mid_row;
            r_j   <= enc_l1;
        end
        if (i_cmd.alc_low) begin
            r_slot   <= SW'({r_row, enc_l0});
            r_status <= dsa_pkg::ST_ALLOC;
        end
        if (i_cmd.rel_rd) begin
            r_row <= rel_row;
            r_i1  <= rel_i1;
            r_j   <= WL'(r_slot >> WL);
        end
        if (i_cmd.rel_wr) begin
            r_status <= dup ? dsa_pkg::ST_DUP : dsa_pkg::ST_RELEASED;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_slot * r_dsize);
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_slot   <= is_alloc ? 10'(r_slot) : '0;
            r_o_cpu    <= is_alloc ? (r_cpu_base + 64'(r_prod)) : '0;
            r_o_gpu    <= is_alloc ? (r_gpu_base + 64'(r_prod)) : '0;
            r_o_spare  <= 12'(SPW'(fresh) + SPW'(r_count));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_slot_out    = r_o_slot;
    assign o_cpu_address = r_o_cpu;
    assign o_gpu_address = r_o_gpu;
    assign o_spare_count = r_o_spare;

    // summary bits and the recycled count must agree
    a_count_vs_l2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_l2 == '0))
        else $error("recycled count disagrees with summary bitmap");

    // the search only descends into rows flagged nonzero
    a_low_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alc_low |-> (l0_eff != '0))
        else $error("slot search reached an empty row");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(CAPACITY) >= r_count)
        else $error("recycled count above capacity");

    // a duplicate release must leave the count alone
    a_dup_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rel_wr && dup) |=> $stable(r_count))
        else $error("duplicate release changed recycled count");

endmodule

// ----- src/descriptor_slot_allocator_core.sv -----
// Descriptor slot allocator.
// Input channel (i_in_valid / o_in_ready): i_op 0 allocates a slot, 1 releases
// i_slot_in. Each transfer yields exactly one result on the output channel
// (o_out_valid / i_out_ready): status, slot, CPU and GPU byte addresses and the
// spare slot count after the request.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_addr
// (0 total count, 1 descriptor size, 2 CPU base, 3 GPU base); write only while idle.
// One request is in flight at a time. A release reads the bitmap rows, then writes
// them back. An allocate of a recycled slot walks a three-level bitmap tree (summary
// flops, then two 32-bit-wide memories with registered reads), one level per cycle;
// an allocate from the bump pointer skips the walk, and an exhausted one also skips
// the slot times size product, which otherwise has a state of its own. The next
// input transfer is taken in the cycle after the result is loaded.
// Results sit in an output register: the block takes the next request while a
// result waits, and holds a new result until the receiver has taken the old one.
// Reset (synchronous, active low) empties the recycled set, rewinds the bump
// pointer and restores the register defaults; no clearing pass is needed.
module descriptor_slot_allocator_core #(
    parameter int CAPACITY = dsa_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  dsa_pkg::t_cfg_idx   i_cfg_addr,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [9:0]          i_slot_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [9:0]          o_slot_out,
    output logic [63:0]         o_cpu_address,
    output logic [63:0]         o_gpu_address,
    output logic [11:0]         o_spare_count
);

    dsa_pkg::t_cmd cmd;
    dsa_pkg::t_sts sts;

    dsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    dsa_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_slot_in     (i_slot_in),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_cpu_address (o_cpu_address),
        .o_gpu_address (o_gpu_address),
        .o_spare_count (o_spare_count)
    );

endmodule

// ----- verif/tb_descriptor_slot_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_descriptor_slot_allocator_core;

    localparam int   CAP          = dsa_pkg::CAPACITY_DEF;
    localparam int   SETTLE       = 10;
    localparam int   STUCK_LIMIT  = 2000;
    localparam int   PHASES       = 8;
    localparam int   PHASE_ITEMS  = 235;

    typedef struct packed {
        dsa_pkg::t_status status;
        logic [9:0]       slot;
        logic [63:0]      cpu;
        logic [63:0]      gpu;
        logic [11:0]      spare;
    } t_slot_result;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              op;
        logic [9:0]        slot;
        dsa_pkg::t_cfg_idx reg_idx;
        logic [63:0]       reg_data;
        bit                pinned;
        t_slot_result      want;
    } t_plan_row;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_wr_en = 1'b0;
    dsa_pkg::t_cfg_idx cfg_addr  = dsa_pkg::CFG_TOTAL_COUNT;
    logic [63:0]       cfg_data  = '0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    logic              req_op    = dsa_pkg::OP_ALLOC;
    logic [9:0]        req_slot  = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    logic [1:0]        rsp_status;
    logic [9:0]        rsp_slot;
    logic [63:0]       rsp_cpu;
    logic [63:0]       rsp_gpu;
    logic [11:0]       rsp_spare;

    // allocator image
    logic [CAP-1:0] free_bits;
    logic [10:0]    bump_ptr;
    logic [10:0]    free_total;
    logic [10:0]    reg_total;
    logic [12:0]    reg_size;
    logic [63:0]    reg_cpu_base;
    logic [63:0]    reg_gpu_base;

    // slots handed out and not yet given back, used to shape releases
    logic [CAP-1:0] live_bits;
    int             live_total;

    t_slot_result pending[$];
    int           errors      = 0;
    int           stuck_cycles = 0;
    bit           calm        = 1'b0;
    t_plan_row    plan[$];

    descriptor_slot_allocator_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (req_valid),
        .o_in_ready    (req_ready),
        .i_op          (req_op),
        .i_slot_in     (req_slot),
        .o_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .o_status      (rsp_status),
        .o_slot_out    (rsp_slot),
        .o_cpu_address (rsp_cpu),
        .o_gpu_address (rsp_gpu),
        .o_spare_count (rsp_spare)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_slot_result predict_request(input logic op,
                                                     input logic [9:0] slot_in);
        t_slot_result r;
        bit           found;
        int           bound;
        logic [63:0]  offset;
        r      = '0;
        found  = 1'b0;
        bound  = (int'(reg_total) > CAP) ? CAP : int'(reg_total);
        if (op == dsa_pkg::OP_ALLOC) begin
            // lowest recycled slot wins over the bump pointer
            for (int i = 0; i < CAP; i++) begin
                if (!found && free_bits[i]) begin
                    free_bits[i] = 1'b0;
                    free_total   = free_total - 11'd1;
                    r.slot       = 10'(i);
                    found        = 1'b1;
                end
            end
            if (!found && int'(bump_ptr) < bound) begin
                r.slot   = bump_ptr[9:0];
                bump_ptr = bump_ptr + 11'd1;
                found    = 1'b1;
            end
            if (found) begin
                offset   = 64'(r.slot) * 64'(reg_size);
                r.status = dsa_pkg::ST_ALLOC;
                r.cpu    = reg_cpu_base + offset;
                r.gpu    = reg_gpu_base + offset;
            end else begin
                r.status = dsa_pkg::ST_EXHAUSTED;
            end
        end else if (int'(slot_in) >= CAP || free_bits[slot_in]) begin
            r.status = dsa_pkg::ST_DUP;
        end else begin
            free_bits[slot_in] = 1'b1;
            free_total         = free_total + 11'd1;
            r.status           = dsa_pkg::ST_RELEASED;
        end
        r.spare = 12'(((int'(bump_ptr) < bound) ? bound - int'(bump_ptr) : 0)
                      + int'(free_total));
        return r;
    endfunction

    function automatic logic [9:0] find_set(input logic [CAP-1:0] bits, input int start);
        logic [9:0] idx;
        bit         hit;
        idx = 10'(start);
        hit = 1'b0;
        for (int k = 0; k < CAP; k++) begin
            if (!hit && bits[(start + k) % CAP]) begin
                idx = 10'((start + k) % CAP);
                hit = 1'b1;
            end
        end
        return idx;
    endfunction

    // mostly give back a live slot; some duplicates and stray indexes as noise
    function automatic logic [9:0] pick_release_slot();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75 && live_total > 0)
            return find_set(live_bits, $urandom_range(0, CAP - 1));
        if (pick < 87 && free_total != 0)
            return find_set(free_bits, $urandom_range(0, CAP - 1));
        return 10'($urandom);
    endfunction

    function automatic logic [63:0] pick_base(input int mode);
        case (mode)
            0:       return {$urandom, $urandom};
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return {32'hFFFF_FFFF, $urandom} & 64'hFFFF_FFFF_FFFF_F000;
        endcase
    endfunction

    function automatic t_plan_row req_row(input logic op, input logic [9:0] slot);
        t_plan_row row;
        row        = '{kind: ROW_REQ, op: op, slot: slot, reg_idx: dsa_pkg::CFG_TOTAL_COUNT,
                       reg_data: '0, pinned: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_plan_row pinned_row(input logic op, input logic [9:0] slot,
                                             input dsa_pkg::t_status st,
                                             input logic [9:0] got_slot,
                                             input logic [63:0] ca, input logic [63:0] ga,
                                             input logic [11:0] spare);
        t_plan_row row;
        row        = req_row(op, slot);
        row.pinned = 1'b1;
        row.want   = '{status: st, slot: got_slot, cpu: ca, gpu: ga, spare: spare};
        return row;
    endfunction

    function automatic t_plan_row reg_row(input dsa_pkg::t_cfg_idx idx,
                                          input logic [63:0] data);
        t_plan_row row;
        row          = req_row(dsa_pkg::OP_ALLOC, '0);
        row.kind     = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic send_request(input logic op, input logic [9:0] slot, input bit pinned,
                                input t_slot_result want);
        t_slot_result predicted;
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_slot  <= slot;
        do @(posedge clk); while (!req_ready);
        predicted = predict_request(op, slot);
        if (predicted.status == dsa_pkg::ST_ALLOC) begin
            live_bits[predicted.slot] = 1'b1;
            live_total++;
        end else if (predicted.status == dsa_pkg::ST_RELEASED && live_bits[slot]) begin
            live_bits[slot] = 1'b0;
            live_total--;
        end
        pending.push_back(pinned ? want : predicted);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input dsa_pkg::t_cfg_idx idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            dsa_pkg::CFG_TOTAL_COUNT: reg_total    = data[10:0];
            dsa_pkg::CFG_DESC_SIZE:   reg_size     = data[12:0];
            dsa_pkg::CFG_CPU_BASE:    reg_cpu_base = data;
            dsa_pkg::CFG_GPU_BASE:    reg_gpu_base = data;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // receiver stalls
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk) begin : check_rsp
        t_slot_result want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
            end else begin
                want = pending.pop_front();
                if (rsp_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_status);
                    errors++;
                end
                if (rsp_slot !== want.slot) begin
                    $error("slot_out: expected %0d, got %0d", want.slot, rsp_slot);
                    errors++;
                end
                if (rsp_cpu !== want.cpu) begin
                    $error("cpu_address: expected %h, got %h", want.cpu, rsp_cpu);
                    errors++;
                end
                if (rsp_gpu !== want.gpu) begin
                    $error("gpu_address: expected %h, got %h", want.gpu, rsp_gpu);
                    errors++;
                end
                if (rsp_spare !== want.spare) begin
                    $error("spare_count: expected %0d, got %0d", want.spare, rsp_spare);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_wr_en || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_slot_result none;
        int           alloc_pct[PHASES];
        int           tot;
        logic [12:0]  size;

        none       = '0;
        alloc_pct  = '{55, 75, 40, 90, 50, 65, 35, 60};
        free_bits  = '0;
        bump_ptr   = '0;
        free_total = '0;
        reg_total    = dsa_pkg::TOTAL_COUNT_RST;
        reg_size     = dsa_pkg::DESC_SIZE_RST;
        reg_cpu_base = '0;
        reg_gpu_base = '0;
        live_bits  = '0;
        live_total = 0;

        // defaults after reset, then reuse order, then a heap shrunk to nothing,
        // zero descriptor size and a total above capacity
        plan.push_back(pinned_row(dsa_pkg::OP_ALLOC,   10'd0,    dsa_pkg::ST_ALLOC,
                                  10'd0, 64'd0,  64'd0,  12'd1023));
        plan.push_back(pinned_row(dsa_pkg::OP_ALLOC,   10'h3FF,  dsa_pkg::ST_ALLOC,
                                  10'd1, 64'd32, 64'd32, 12'd1022));
        plan.push_back(pinned_row(dsa_pkg::OP_RELEASE, 10'd1,    dsa_pkg::ST_RELEASED,
                                  10'd0, 64'd0,  64'd0,  12'd1023));
        plan.push_back(pinned_row(dsa_pkg::OP_RELEASE, 10'd1,    dsa_pkg::ST_DUP,
                                  10'd0, 64'd0,  64'd0,  12'd1023));
        plan.push_back(pinned_row(dsa_pkg::OP_RELEASE, 10'd1023, dsa_pkg::ST_RELEASED,
                                  10'd0, 64'd0,  64'd0,  12'd1024));
        plan.push_back(pinned_row(dsa_pkg::OP_RELEASE, 10'd0,    dsa_pkg::ST_RELEASED,
                                  10'd0, 64'd0,  64'd0,  12'd1025));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(req_row(dsa_pkg::OP_RELEASE, 10'd1023));
        plan.push_back(reg_row(dsa_pkg::CFG_TOTAL_COUNT, 64'd0));
        plan.push_back(reg_row(dsa_pkg::CFG_DESC_SIZE,   64'd4096));
        plan.push_back(reg_row(dsa_pkg::CFG_CPU_BASE,    64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(reg_row(dsa_pkg::CFG_GPU_BASE,    64'h8000_0000_0000_0000));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(pinned_row(dsa_pkg::OP_ALLOC,   10'd0,    dsa_pkg::ST_EXHAUSTED,
                                  10'd0, 64'd0, 64'd0, 12'd0));
        plan.push_back(pinned_row(dsa_pkg::OP_RELEASE, 10'h2AA,  dsa_pkg::ST_RELEASED,
                                  10'd0, 64'd0, 64'd0, 12'd1));
        plan.push_back(pinned_row(dsa_pkg::OP_RELEASE, 10'h155,  dsa_pkg::ST_RELEASED,
                                  10'd0, 64'd0, 64'd0, 12'd2));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(pinned_row(dsa_pkg::OP_ALLOC,   10'd0,    dsa_pkg::ST_EXHAUSTED,
                                  10'd0, 64'd0, 64'd0, 12'd0));
        plan.push_back(reg_row(dsa_pkg::CFG_DESC_SIZE,   64'd0));
        plan.push_back(reg_row(dsa_pkg::CFG_TOTAL_COUNT, 64'd2047));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(req_row(dsa_pkg::OP_RELEASE, 10'd3));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));
        plan.push_back(reg_row(dsa_pkg::CFG_DESC_SIZE,   64'd8191));
        plan.push_back(req_row(dsa_pkg::OP_ALLOC, 10'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_request(plan[i].op, plan[i].slot, plan[i].pinned, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0:       tot = int'(bump_ptr) + $urandom_range(0, 24);
                1:       tot = $urandom_range(0, int'(bump_ptr));
                2:       tot = (ph < 4) ? 2047 : 1024;
                default: tot = $urandom_range(0, 2047);
            endcase
            if (tot > 2047) tot = 2047;
            case (ph % 5)
                0:       size = 13'd1;
                1:       size = 13'd4096;
                2:       size = 13'd8191;
                3:       size = 13'd0;
                default: size = 13'($urandom);
            endcase
            write_reg(dsa_pkg::CFG_TOTAL_COUNT, 64'(tot));
            write_reg(dsa_pkg::CFG_DESC_SIZE,   64'(size));
            write_reg(dsa_pkg::CFG_CPU_BASE,    pick_base(ph % 3));
            write_reg(dsa_pkg::CFG_GPU_BASE,    pick_base((ph + 2) % 3));
            if (ph == PHASES - 1) calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < alloc_pct[ph])
                    send_request(dsa_pkg::OP_ALLOC, 10'($urandom), 1'b0, none);
                else
                    send_request(dsa_pkg::OP_RELEASE, pick_release_slot(), 1'b0, none);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/dsa_pkg.sv
src/dsa_ctrl.sv
src/dsa_dpath.sv
src/descriptor_slot_allocator_core.sv
verif/tb_descriptor_slot_allocator_core.sv
